### rtl/fmcp_pkg.sv
`default_nettype none

package fmcp_pkg;

  localparam int MAX_CHARS_DEF = 9;

  localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [15:0] RADIX = 16'd10;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ECHO,
    ST_CMD
  } state_t;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        tx_send;
    logic        direction;
    logic [15:0] duty;
    logic        paused_now;
    logic        last;
  } res_t;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic       clear;
    logic       step;
    logic [7:0] digit;
  } mac_ctl_t;

endpackage

`default_nettype wire

### rtl/fmcp_mac.sv
`default_nettype none

module fmcp_mac
  import fmcp_pkg::*;
(
  input  wire logic        clk,
  input  wire mac_ctl_t    ctl,
  output logic [15:0]      value
);

  logic [15:0] value_r;
  logic [15:0] value_nxt;

  // value*10 + digit - '0', wrapping at 16 bits
  always_comb begin
    value_nxt = value_r;
    if (ctl.clear) begin
      value_nxt = '0;
    end else if (ctl.step) begin
      value_nxt = 16'(value_r * RADIX) + {8'd0, ctl.digit} - {8'd0, CH_ZERO};
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

`default_nettype wire

### rtl/fmcp_ctrl.sv
`default_nettype none

module fmcp_ctrl
  import fmcp_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_t             res,
  output mac_ctl_t         mac_ctl,
  input  wire logic [15:0] mac_value
);

  localparam int LEN_W = $clog2(MAX_CHARS + 1);
  localparam int IDX_W = $clog2(MAX_CHARS);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CHARS);

  state_t           state_r, state_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic             paused_r, paused_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       store_r [MAX_CHARS];
  logic             store_we;

  logic             accept;
  logic             echo_last;
  logic             first_plus;
  logic             first_minus;
  logic             cmd_pause;

  // ready only in idle, so the request is taken there whenever valid
  assign accept      = in_valid && (state_r == ST_IDLE);
  assign echo_last   = (LEN_W'(idx_r) + LEN_W'(1)) == len_r;
  assign first_plus  = (len_r != '0) && (store_r[0] == CH_PLUS);
  assign first_minus = (len_r != '0) && (store_r[0] == CH_MINUS);
  assign cmd_pause   = (first_plus || first_minus) ? paused_r : !paused_r;

  always_comb begin
    state_nxt    = state_r;
    in_frame_nxt = in_frame_r;
    paused_nxt   = paused_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    store_we     = 1'b0;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    mac_ctl      = '0;
    mac_ctl.digit = store_r[idx_r];

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (rx_byte == CH_OPEN) begin
            len_nxt      = '0;
            in_frame_nxt = 1'b1;
          end else if (rx_byte == CH_CLOSE) begin
            in_frame_nxt  = 1'b0;
            idx_nxt       = '0;
            mac_ctl.clear = 1'b1;
            state_nxt     = (len_r != '0) ? ST_ECHO : ST_CMD;
          end else if (in_frame_r && rx_byte != CH_NUL && len_r < LEN_MAX) begin
            store_we = 1'b1;
            len_nxt  = len_r + LEN_W'(1);
          end
        end
      end

      ST_ECHO: begin
        res_valid      = 1'b1;
        res.kind       = KIND_ECHO;
        res.tx_byte    = store_r[idx_r];
        res.tx_send    = !paused_r;
        res.paused_now = paused_r;
        if (res_ready) begin
          // first character sets direction and stays out of the sum
          mac_ctl.step = (idx_r != '0);
          if (echo_last) begin
            state_nxt = ST_CMD;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      ST_CMD: begin
        res_valid      = 1'b1;
        res.kind       = KIND_CMD;
        res.tx_byte    = mac_value[7:0];
        res.tx_send    = !cmd_pause;
        res.direction  = first_plus;
        res.duty       = mac_value;
        res.paused_now = cmd_pause;
        res.last       = 1'b1;
        if (res_ready) begin
          paused_nxt = cmd_pause;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_frame_r <= 1'b0;
      paused_r   <= 1'b0;
      len_r      <= '0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      in_frame_r <= in_frame_nxt;
      paused_r   <= paused_nxt;
      len_r      <= len_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[len_r[IDX_W-1:0]] <= rx_byte;
    end
  end

`ifndef SYNTH
  a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ready)
    else $error("input taken while results pending");

  a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX)
    else $error("text length beyond capacity");

  a_cmd_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMD && res_ready) |=> (state_r == ST_IDLE && in_ready))
    else $error("command result did not return to idle");
`endif

endmodule

`default_nettype wire

### rtl/framed_motor_command_parser.sv
// channel | dir | handshake          | payload
// in_     | in  | in_tvalid/tready   | tdata[7:0] rx_byte
// out_    | out | out_tvalid/tready  | tdata kind-less fields, tuser kind, tlast last
//
// bytes other than '>' keep the block in idle, so it is ready again next cycle
// '>' with n stored characters gives n echoes and one command result, with
// one step of the shared multiply-accumulate unit per echo after the first
// synchronous active-low reset empties the text, closes the frame, clears pause
// the output register holds a result while out_tready is low; the sequencer waits
`default_nettype none

module framed_motor_command_parser
  import fmcp_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] tx_byte, [8] tx_send, [9] direction,
                                       // [25:10] duty, [26] paused_now, zero above
  output logic             out_tuser,  // [0] kind
  output logic             out_tlast
);

  logic     res_valid;
  logic     res_ready;
  res_t     res;
  mac_ctl_t mac_ctl;
  logic [15:0] mac_value;

  logic out_valid_r;
  res_t out_res_r;

  fmcp_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .value (mac_value)
  );

  fmcp_ctrl #(
    .MAX_CHARS (MAX_CHARS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mac_ctl   (mac_ctl),
    .mac_value (mac_value)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {5'd0, out_res_r.paused_now, out_res_r.duty,
                       out_res_r.direction, out_res_r.tx_send, out_res_r.tx_byte};

`ifndef SYNTH
  a_last_on_command: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == out_tlast))
    else $error("last flag not tied to command result");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
  import fmcp_pkg::*;

  localparam int TEXT_MAX = MAX_CHARS_DEF;

  // mirrors the parser: keeps the frame text, the pause flag and the results still owed
  class cmd_scoreboard;
    bit              framed;
    logic [7:0]      text [TEXT_MAX];
    int unsigned     text_len;
    bit              paused;
    res_t            awaited [$];
    int unsigned     mismatches;
    int unsigned     results_seen;

    function new();
      framed = 1'b0;
      foreach (text[i]) text[i] = CH_NUL;
      text_len = 0;
      paused = 1'b0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    // bytes outside a frame other than the two brackets do nothing
    function bit has_effect(logic [7:0] b);
      return b == CH_OPEN || b == CH_CLOSE || framed;
    endfunction

    function void note_request(logic [7:0] b);
      res_t        r;
      logic        dir;
      logic [15:0] value;
      if (b == CH_OPEN) begin
        foreach (text[i]) text[i] = CH_NUL;
        text_len = 0;
        framed = 1'b1;
        return;
      end
      if (b != CH_CLOSE) begin
        if (framed && b != CH_NUL && text_len < TEXT_MAX) begin
          text[text_len] = b;
          text_len++;
        end
        return;
      end
      framed = 1'b0;
      for (int i = 0; i < text_len; i++) begin
        r = '0;
        r.kind = KIND_ECHO;
        r.tx_byte = text[i];
        r.tx_send = !paused;
        r.paused_now = paused;
        awaited.push_back(r);
      end
      dir = 1'b0;
      if (text_len > 0 && text[0] == CH_PLUS) begin
        dir = 1'b1;
      end else if (text_len > 0 && text[0] == CH_MINUS) begin
        dir = 1'b0;
      end else begin
        paused = !paused;
      end
      // non-digits go through the same sum, wrapping at 16 bits
      value = '0;
      for (int i = 1; i < text_len; i++)
        value = value * RADIX + {8'h00, text[i]} - {8'h00, CH_ZERO};
      r = '0;
      r.kind = KIND_CMD;
      r.tx_byte = value[7:0];
      r.tx_send = !paused;
      r.direction = dir;
      r.duty = value;
      r.paused_now = paused;
      r.last = 1'b1;
      awaited.push_back(r);
    endfunction

    function void check_result(logic [31:0] data, logic user, logic lst);
      res_t exp_r;
      res_t got;
      bit   bad;
      results_seen++;
      got.kind = user;
      got.tx_byte = data[7:0];
      got.tx_send = data[8];
      got.direction = data[9];
      got.duty = data[25:10];
      got.paused_now = data[26];
      got.last = lst;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d byte %h send %0d dir %0d duty %h pz %0d last %0d",
                   got.kind, got.tx_byte, got.tx_send, got.direction, got.duty,
                   got.paused_now, got.last);
        return;
      end
      exp_r = awaited.pop_front();
      bad = got.kind !== exp_r.kind || got.tx_byte !== exp_r.tx_byte ||
            got.tx_send !== exp_r.tx_send || got.direction !== exp_r.direction ||
            got.duty !== exp_r.duty || got.paused_now !== exp_r.paused_now ||
            got.last !== exp_r.last || data[31:27] !== 5'd0;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t, result %0d", $realtime, results_seen);
          $display("  expected: kind %0d byte %h send %0d dir %0d duty %h pz %0d last %0d",
                   exp_r.kind, exp_r.tx_byte, exp_r.tx_send, exp_r.direction, exp_r.duty,
                   exp_r.paused_now, exp_r.last);
          $display("  actual:   kind %0d byte %h send %0d dir %0d duty %h pz %0d last %0d pad %h",
                   got.kind, got.tx_byte, got.tx_send, got.direction, got.duty,
                   got.paused_now, got.last, data[31:27]);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  cmd_scoreboard sb = new();

  int unsigned bytes_counted = 0;
  int unsigned idle_pct = 30;
  bit          calm = 1'b0;
  bit          held_once = 1'b0;

  framed_motor_command_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  // one request on the input, with an optional gap in front of it
  task push_byte(input logic [7:0] b);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    if (sb.has_effect(b)) bytes_counted++;
    sb.note_request(b);
    if (bytes_counted >= 350) calm = 1'b1;
  endtask

  task send_frame();
    int unsigned n;
    int unsigned pick;
    logic [7:0]  c;
    idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
    push_byte(CH_OPEN);
    pick = $urandom_range(0, 9);
    if (pick < 4) push_byte(CH_PLUS);
    else if (pick < 8) push_byte(CH_MINUS);
    else if (pick == 8) push_byte(8'($urandom_range(0, 255)));
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 6);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) != 0) c = CH_ZERO + 8'($urandom_range(0, 9));
      else c = 8'($urandom_range(0, 255));
      push_byte(c);
    end
    // now and then the frame is left open
    if ($urandom_range(0, 15) != 0) push_byte(CH_CLOSE);
  endtask

  initial begin
    logic [7:0] opening [$];
    int unsigned pick;
    opening = '{8'hFF, CH_CLOSE,
                CH_OPEN, CH_MINUS, CH_NUL, 8'hFF, CH_CLOSE,
                CH_OPEN, 8'h7A, CH_OPEN, CH_PLUS,
                CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_ZERO + 8'd9,
                CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_ZERO + 8'd9,
                CH_ZERO + 8'd9, CH_CLOSE, CH_CLOSE,
                CH_OPEN, CH_CLOSE, 8'h41};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) push_byte(opening[i]);
    bytes_counted = 0;

    while (bytes_counted < 400) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) push_byte(8'($urandom_range(0, 255)));
      else if (pick == 1) push_byte(CH_CLOSE);
      else send_frame();
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver readiness: random stalls, one long hold so the input backs up
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && !held_once && sb.results_seen >= 60) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        out_tready <= 1'b1;
        held_once = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser, out_tlast);
  end

endmodule

`default_nettype wire
